// ----- rtl/wcm_pkg.sv -----
package wcm_pkg;

    // Pattern store depth and derived widths
    localparam int MAX_PATTERN = 64;
    localparam int POS_W       = MAX_PATTERN + 1;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // Wildcard byte
    localparam logic [7:0] STAR_BYTE = 8'd42;

    // Operation codes carried in tuser
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_TEXT   = 2'd2;
    localparam logic [1:0] OP_END    = 2'd3;

    // One decoded word, valid only in the cycle it is processed
    typedef struct packed {
        logic       clear;
        logic       append;
        logic       text;
        logic       fin;
        logic [7:0] data;
    } cmd_t;

    // Pattern view handed to the active-set logic
    typedef struct packed {
        logic [MAX_PATTERN-1:0] star;
        logic [MAX_PATTERN-1:0] lit;
        logic [POS_W-1:0]       rearm;
        logic [LEN_W-1:0]       len;
        logic                   ovf;
    } pat_status_t;

endpackage

// ----- rtl/wcm_pattern.sv -----
module wcm_pattern
    import wcm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output pat_status_t pstat
);

    logic [7:0]             pat_mem_reg [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] star_reg;
    logic [MAX_PATTERN-1:0] live_reg, live_next;
    logic [POS_W-1:0]       rearm_reg, rearm_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   ovf_reg, ovf_next;
    logic                   full;
    logic                   is_star;
    logic                   do_write;
    logic [IDX_W-1:0]       wr_idx;

    assign full     = (len_reg == LEN_W'(MAX_PATTERN));
    assign is_star  = (cmd.data == STAR_BYTE);
    assign do_write = cmd.append && !full;
    assign wr_idx   = len_reg[IDX_W-1:0];

    // Update length, live mask, rearm set and overflow flag
    always_comb begin
        len_next   = len_reg;
        live_next  = live_reg;
        rearm_next = rearm_reg;
        ovf_next   = ovf_reg;
        if (cmd.clear) begin
            len_next   = '0;
            live_next  = '0;
            rearm_next = POS_W'(1);
            ovf_next   = 1'b0;
        end else if (cmd.append) begin
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                len_next = len_reg + LEN_W'(1);
                for (int i = 0; i < MAX_PATTERN; i++) begin
                    if (len_reg == LEN_W'(i)) begin
                        live_next[i] = 1'b1;
                        // extend the leading-star run of the rearm set
                        if (rearm_reg[i] && is_star) begin
                            rearm_next[i+1] = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            live_reg  <= '0;
            rearm_reg <= POS_W'(1);
            ovf_reg   <= 1'b0;
        end else begin
            len_reg   <= len_next;
            live_reg  <= live_next;
            rearm_reg <= rearm_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Store the pattern byte and its star mark
    always_ff @(posedge aclk) begin
        if (do_write) begin
            pat_mem_reg[wr_idx] <= cmd.data;
            star_reg[wr_idx]    <= is_star;
        end
    end

    // Compare every live literal position with the text byte
    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            pstat.star[i] = live_reg[i] && star_reg[i];
            pstat.lit[i]  = live_reg[i] && !star_reg[i] && (pat_mem_reg[i] == cmd.data);
        end
        pstat.rearm = rearm_reg;
        pstat.len   = len_reg;
        pstat.ovf   = ovf_reg;
    end

endmodule

// ----- rtl/wcm_active.sv -----
module wcm_active
    import wcm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    input  pat_status_t pstat,
    output logic        matched
);

    logic [POS_W-1:0] act_reg, act_next;
    logic             armed_reg, armed_next;
    logic [POS_W-1:0] act_eff;
    logic [POS_W-1:0] shifted;
    logic [POS_W-1:0] star_m;
    logic [POS_W-1:0] gen;
    logic [POS_W-1:0] sum;
    logic [POS_W-1:0] carries;

    // While armed the active set is the pattern's rearm set
    assign act_eff = armed_reg ? pstat.rearm : act_reg;

    // Stars keep their position, matching literals step forward
    assign shifted = {1'b0, act_eff[MAX_PATTERN-1:0] & pstat.star}
                   | {act_eff[MAX_PATTERN-1:0] & pstat.lit, 1'b0};

    // Close over star runs with a carry chain: carry passes a star position
    assign star_m  = {1'b0, pstat.star};
    assign gen     = shifted & star_m;
    assign sum     = star_m + gen;
    assign carries = sum ^ star_m ^ gen;

    always_comb begin
        act_next   = act_reg;
        armed_next = armed_reg;
        if (cmd.clear || cmd.append || cmd.fin) begin
            armed_next = 1'b1;
        end else if (cmd.text) begin
            act_next   = shifted | carries;
            armed_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg   <= '0;
            armed_reg <= 1'b1;
        end else begin
            act_reg   <= act_next;
            armed_reg <= armed_next;
        end
    end

    // Verdict: end position reached and no overflow
    assign matched = act_eff[pstat.len] && !pstat.ovf;

endmodule

// ----- rtl/star_wildcard_matcher_unit.sv -----
// Whole-string matcher where '*' stands for any run of bytes, including an empty one.
// Each word carries an operation in s_tuser (clear pattern, append pattern byte, text
// byte, end of text) and a byte in s_tdata. The pattern (up to 64 bytes) is kept until
// the next clear; a longer pattern sets a sticky overflow flag that forces no match.
// Only an end-of-text word yields a result word, with the verdict and the overflow flag,
// and it rearms the matcher for the next string; a clear or an append also rearms. A word
// is registered at the input, the whole active-position set is updated in one step by
// parallel byte compares and a carry chain across star positions, and the result is
// registered at the output, so a word is accepted every cycle unless an end-of-text word
// waits on a stalled result word; a result word passes through the input register and then
// the result register. An end-of-text word that meets a stalled result word waits in the
// input register and holds off further input until the result word is taken.
module star_wildcard_matcher_unit
    import wcm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [1:0] s_tuser,   // [1:0] operation
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

    logic       a_valid_reg;
    logic [1:0] a_op_reg;
    logic [7:0] a_byte_reg;
    logic       m_valid_reg;
    logic       m_match_reg;
    logic       m_ovf_reg;
    logic       out_free;
    logic       fire;
    logic       matched;
    cmd_t        cmd;
    pat_status_t pstat;

    // Output slot free, and the held word moves on
    assign out_free = !m_valid_reg || m_tready;
    assign fire     = a_valid_reg && ((a_op_reg != OP_END) || out_free);
    assign s_tready = !a_valid_reg || fire;

    // Hold the input word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_tready) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            a_op_reg   <= s_tuser;
            a_byte_reg <= s_tdata;
        end
    end

    // Decode the word being processed
    always_comb begin
        cmd.clear  = fire && (a_op_reg == OP_CLEAR);
        cmd.append = fire && (a_op_reg == OP_APPEND);
        cmd.text   = fire && (a_op_reg == OP_TEXT);
        cmd.fin    = fire && (a_op_reg == OP_END);
        cmd.data   = a_byte_reg;
    end

    wcm_pattern u_pattern (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .pstat   (pstat)
    );

    wcm_active u_active (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .pstat   (pstat),
        .matched (matched)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.fin) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin) begin
            m_match_reg <= matched;
            m_ovf_reg   <= pstat.ovf;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_ovf_reg, m_match_reg};

endmodule

// ----- rtl/wcm_checker.sv -----
module wcm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic [1:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // No result word straight after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word after reset");

    // Stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // Stalled input word holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("stalled input word changed");

    // A match is never reported with overflow, and padding stays zero
    a_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]) && (m_tdata[7:2] == 6'd0))
        else $error("inconsistent result word");

    // Input never stalls while the output side can take a word
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled with free output");

endmodule

bind star_wildcard_matcher_unit wcm_checker u_wcm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
